// ----- sv/pfe_pkg.sv -----
package pfe_pkg;

    // default configuration
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_UNDER = 3'd1;
    localparam t_status ST_OVER  = 3'd2;
    localparam t_status ST_DIV0  = 3'd3;
    localparam t_status ST_EMPTY = 3'd4;

    // shift control broadcast to every stack cell
    typedef struct packed {
        logic push;   // take the value from the cell above
        logic pop;    // take the value from the cell below
    } t_cell_ctl;

    // request to the iterative arithmetic unit
    typedef struct packed {
        logic start;
        logic is_mul;
    } t_alu_req;

endpackage

// ----- sv/pfe_cell.sv -----
module pfe_cell #(
    parameter int W = pfe_pkg::DEF_VALUE_WIDTH
) (
    input  logic              i_clk,
    input  pfe_pkg::t_cell_ctl i_ctl,
    input  logic [W-1:0]      i_above,
    input  logic [W-1:0]      i_below,
    output logic [W-1:0]      o_value
);
    import pfe_pkg::*;

    logic [W-1:0] r_value;

    // one stack slot: shift down on push, up on pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_value <= i_above;
        end else if (i_ctl.pop) begin
            r_value <= i_below;
        end
    end

    assign o_value = r_value;

endmodule

// ----- sv/pfe_alu.sv -----
module pfe_alu #(
    parameter int W = pfe_pkg::DEF_VALUE_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfe_pkg::t_alu_req i_req,
    input  logic [W-1:0]      i_lhs,
    input  logic [W-1:0]      i_rhs,
    output logic              o_done,
    output logic [W-1:0]      o_result
);
    import pfe_pkg::*;

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_is_mul;
    logic          r_neg;
    logic [W-1:0]  r_x;     // multiplicand or partial remainder
    logic [W-1:0]  r_y;     // multiplier or quotient
    logic [W-1:0]  r_b;     // divisor magnitude
    logic [W-1:0]  r_acc;   // product

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  mag_lhs;
    logic [W-1:0]  mag_rhs;

    // restoring division step
    assign trial   = {r_x, r_y[W-1]};
    assign diff    = trial - {1'b0, r_b};
    assign ge      = trial >= {1'b0, r_b};
    assign mag_lhs = i_lhs[W-1] ? (~i_lhs + 1'b1) : i_lhs;
    assign mag_rhs = i_rhs[W-1] ? (~i_rhs + 1'b1) : i_rhs;

    // control: one bit per cycle over all W bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift-add multiply, restoring divide of magnitudes
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_mul <= i_req.is_mul;
            r_neg    <= i_lhs[W-1] ^ i_rhs[W-1];
            r_acc    <= '0;
            r_b      <= mag_rhs;
            if (i_req.is_mul) begin
                r_x <= i_lhs;
                r_y <= i_rhs;
            end else begin
                r_x <= '0;
                r_y <= mag_lhs;
            end
        end else if (r_busy) begin
            if (r_is_mul) begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[W-2:0], 1'b0};
                r_y <= {1'b0, r_y[W-1:1]};
            end else begin
                r_x <= ge ? diff[W-1:0] : trial[W-1:0];
                r_y <= {r_y[W-2:0], ge};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_is_mul ? r_acc : (r_neg ? (~r_y + 1'b1) : r_y);

endmodule

// ----- sv/postfix_expression_evaluator.sv -----
// Postfix evaluator on a shifting stack of cells.
// Operands, + and - are handled directly; * and / go to the shared
// shift-add / restoring-divide unit; the final word of an expression then
// passes through S_FIN, which loads the result register.
// New words are stalled while * or / is in progress and while in S_FIN.
// Reset (synchronous, active low) empties the stack and clears the error.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = pfe_pkg::DEF_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_symbol,
    input  logic                 i_end_of_expr,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_value,
    output pfe_pkg::t_status     o_status
);
    import pfe_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int D   = STACK_DEPTH;
    localparam int SPW = $clog2(D + 1);
    localparam int EW  = W + 9;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [SPW-1:0]  r_sp, n_sp;
    t_status         r_err, n_err;
    logic            r_last, n_last;
    logic            r_valid, n_valid;
    logic [31:0]     r_value, n_value;
    t_status         r_status, n_status;

    t_cell_ctl       ctl;
    t_alu_req        req;
    logic [W-1:0]    cell_val [D];
    logic [W-1:0]    push_val;
    logic [W-1:0]    pop_val;
    logic [W-1:0]    alu_res;
    logic            alu_done;
    logic [W-1:0]    rhs;
    logic [W-1:0]    lhs;
    logic [EW-1:0]   operand_ext;
    logic [63:0]     top_ext;
    logic            accept;
    logic            is_op;
    logic            out_free;

    assign rhs         = cell_val[0];
    assign lhs         = cell_val[1];
    assign accept      = i_valid && !o_stall;
    assign is_op       = (i_symbol == CH_PLUS) || (i_symbol == CH_MINUS) ||
                         (i_symbol == CH_STAR) || (i_symbol == CH_SLASH);
    assign operand_ext = {{W{1'b0}}, 1'b0, i_symbol} - {{W{1'b0}}, 1'b0, CH_ZERO};
    assign push_val    = operand_ext[W-1:0];
    assign top_ext     = 64'($signed(cell_val[0]));
    assign out_free    = !r_valid || !i_stall;

    // stack of cells, top at index zero
    for (genvar g = 0; g < D; g++) begin : g_cell
        logic [W-1:0] above;
        logic [W-1:0] below;
        if (g == 0) begin : g_top
            assign above = push_val;
            assign below = pop_val;
        end else begin : g_rest
            assign above = cell_val[g-1];
        end
        if (g == D - 1) begin : g_end
            if (g != 0) begin : g_endb
                assign below = cell_val[g];
            end
        end else if (g != 0) begin : g_mid
            assign below = cell_val[g+1];
        end
        pfe_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_above (above),
            .i_below (below),
            .o_value (cell_val[g])
        );
    end

    pfe_alu #(.W(W)) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_lhs    (lhs),
        .i_rhs    (rhs),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    // sequencing of one word
    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_err    = r_err;
        n_last   = r_last;
        n_valid  = r_valid && i_stall;
        n_value  = r_value;
        n_status = r_status;
        ctl      = '0;
        req      = '0;
        pop_val  = alu_res;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last = i_end_of_expr;
                    if (i_end_of_expr) begin
                        n_state = S_FIN;
                    end
                    if (!is_op) begin
                        if (r_sp == SPW'(D)) begin
                            if (r_err == ST_OK) n_err = ST_OVER;
                        end else begin
                            ctl.push = 1'b1;
                            n_sp     = r_sp + 1'b1;
                        end
                    end else if (r_sp < SPW'(2)) begin
                        if (r_err == ST_OK) n_err = ST_UNDER;
                    end else if (i_symbol == CH_PLUS || i_symbol == CH_MINUS) begin
                        pop_val = (i_symbol == CH_PLUS) ? (lhs + rhs) : (lhs - rhs);
                        ctl.pop = 1'b1;
                        n_sp    = r_sp - 1'b1;
                    end else if (i_symbol == CH_SLASH && rhs == '0) begin
                        if (r_err == ST_OK) n_err = ST_DIV0;
                        pop_val = '0;
                        ctl.pop = 1'b1;
                        n_sp    = r_sp - 1'b1;
                    end else begin
                        req.start  = 1'b1;
                        req.is_mul = (i_symbol == CH_STAR);
                        n_state    = S_CALC;
                    end
                end
            end
            S_CALC: begin
                if (alu_done) begin
                    ctl.pop = 1'b1;
                    n_sp    = r_sp - 1'b1;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_valid  = 1'b1;
                    n_value  = (r_sp != '0) ? top_ext[31:0] : 32'd0;
                    if (r_err != ST_OK) begin
                        n_status = r_err;
                    end else if (r_sp == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status = ST_OK;
                    end
                    n_sp     = '0;
                    n_err    = ST_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_err   <= ST_OK;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_err   <= n_err;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule
